### design/slwl_pkg.sv
// slwl_pkg: shared types, constants and helper functions for the
// sliding window log rate limiter. No dependencies; imported by slwl_expiry
// and the top module.
`default_nettype none

package slwl_pkg;

   // sizing
   localparam int TENANTS = 128;
   localparam int DEPTH   = 16;

   // fixed field widths
   localparam int TENANT_W = 7;
   localparam int TS_W     = 48;
   localparam int WINDOW_W = 24;
   localparam int MAXREQ_W = 5;
   localparam int OUTCNT_W = 5;
   localparam int CSR_AW   = 1;
   localparam int CSR_DW   = 24;

   // derived widths
   localparam int TIDX_W = (TENANTS > 1) ? $clog2(TENANTS) : 1;
   localparam int HEAD_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int TS_WORDS = TENANTS * DEPTH;
   localparam int TS_AW  = (TS_WORDS > 1) ? $clog2(TS_WORDS) : 1;

   // register reset values
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(10000);
   localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = MAXREQ_W'(10);

   // register indexes
   localparam logic [CSR_AW-1:0] REG_WINDOW = 1'b0;
   localparam logic [CSR_AW-1:0] REG_MAXREQ = 1'b1;

   typedef logic [TIDX_W-1:0] tidx_type;
   typedef logic [HEAD_W-1:0] head_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [TS_AW-1:0]  ts_addr_type;

   // per-tenant queue descriptor
   typedef struct packed {
      head_type head;
      cnt_type  count;
   } meta_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_META,
      ST_CHK,
      ST_FIN
   } slwl_state_type;

   // circular slot of head plus offset
   function automatic head_type slot_add(input head_type head, input cnt_type offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(offs);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return HEAD_W'(sum);
   endfunction

   // flat timestamp store address of a tenant's slot
   function automatic ts_addr_type ts_addr(input tidx_type t, input head_type s);
      return TS_AW'(TS_AW'(t) * TS_AW'(DEPTH) + TS_AW'(s));
   endfunction

endpackage

`default_nettype wire

### design/slwl_ram.sv
// slwl_ram: generic simple dual-port RAM, one write and one registered read
// port per cycle. No package dependencies.
`default_nettype none

module slwl_ram #(
   parameter int DATA_W = 8,
   parameter int WORDS  = 16,
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [WORDS];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

### design/slwl_expiry.sv
// slwl_expiry: shared age compare unit, decides whether one stored timestamp
// has left the window. Depends on slwl_pkg.
`default_nettype none

module slwl_expiry (
   input  wire logic [slwl_pkg::TS_W-1:0]     now_ms,
   input  wire logic [slwl_pkg::TS_W-1:0]     stamp,
   input  wire logic [slwl_pkg::WINDOW_W-1:0] window_ms,
   output logic                               expire
);
   import slwl_pkg::*;

   logic [TS_W-1:0] age;

   // entries newer than now never expire
   always_comb begin
      age    = now_ms - stamp;
      expire = (now_ms >= stamp) && (age >= TS_W'(window_ms));
   end

endmodule

`default_nettype wire

### design/sliding_window_log_rate_limiter.sv
// Per-tenant sliding window log rate limiter.
// Channels: request transaction (req_tenant, req_now_ms) on req_valid/req_ready,
// one response transaction (rsp_allowed, rsp_expired, rsp_occupancy) per request
// on rsp_valid/rsp_ready. csr_we writes window_ms (index 0) or max_requests
// (index 1) with no handshake; write only while the block is idle.
// Sequence: a request is taken in ST_IDLE, its queue descriptor is read in
// ST_META, then ST_CHK checks the stored timestamps for expiry one at a time
// (up to DEPTH, one read of the timestamp memory and one compare each), then
// ST_FIN appends and responds. The response becomes valid at the edge on which
// the block returns to ST_IDLE and is ready again; it takes no new request
// before the previous one has retired.
// The response sits in an output register, so the next request is accepted
// and processed while it waits; a stalled receiver holds the block only when
// the following response is ready to be written.
// Reset: synchronous, active high; all tenant queues read as empty (per-tenant
// valid flags), registers return to window 10000 ms and limit 10. There is no
// clearing pass: the timestamp memory is only read at counted entries.
// Depends on slwl_pkg, slwl_ram and slwl_expiry.
`default_nettype none

module sliding_window_log_rate_limiter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [slwl_pkg::TENANT_W-1:0]      req_tenant,
   input  wire logic [slwl_pkg::TS_W-1:0]          req_now_ms,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_allowed,
   output logic [slwl_pkg::OUTCNT_W-1:0]           rsp_expired,
   output logic [slwl_pkg::OUTCNT_W-1:0]           rsp_occupancy,
   // configuration
   input  wire logic                               csr_we,
   input  wire logic [slwl_pkg::CSR_AW-1:0]        csr_addr,
   input  wire logic [slwl_pkg::CSR_DW-1:0]        csr_wdata
);
   import slwl_pkg::*;

   slwl_state_type state_ff, state_in;

   logic [WINDOW_W-1:0] window_ff;
   logic [MAXREQ_W-1:0] maxreq_ff;

   tidx_type         tidx_ff, tidx_in;
   logic [TS_W-1:0]  now_ff, now_in;
   logic             oor_ff, oor_in;
   head_type         head_ff, head_in;
   cnt_type          count_ff, count_in;
   cnt_type          dropped_ff, dropped_in;

   logic [TENANTS-1:0] meta_vld_ff, meta_vld_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_allowed_ff, rsp_allowed_in;
   logic [OUTCNT_W-1:0] rsp_expired_ff, rsp_expired_in;
   logic [OUTCNT_W-1:0] rsp_occ_ff, rsp_occ_in;

   // memory ports
   logic        meta_we;
   tidx_type    meta_raddr;
   meta_type    meta_wdata, meta_rdata;
   logic        ts_we;
   ts_addr_type ts_waddr, ts_raddr;
   logic [TS_W-1:0] ts_rdata;

   logic     expire;
   logic     fin_go;
   logic     allowed;
   cnt_type  limit;
   head_type head0, head_nx;
   cnt_type  cnt0;

   // per-tenant head and count
   slwl_ram #(.DATA_W($bits(meta_type)), .WORDS(TENANTS)) u_meta_ram (
      .clock (clock),
      .we    (meta_we),
      .waddr (tidx_ff),
      .wdata (meta_wdata),
      .raddr (meta_raddr),
      .rdata (meta_rdata)
   );

   // timestamp log, DEPTH slots per tenant
   slwl_ram #(.DATA_W(TS_W), .WORDS(TS_WORDS)) u_ts_ram (
      .clock (clock),
      .we    (ts_we),
      .waddr (ts_waddr),
      .wdata (now_ff),
      .raddr (ts_raddr),
      .rdata (ts_rdata)
   );

   // age compare on the entry just read
   slwl_expiry u_expiry (
      .now_ms    (now_ff),
      .stamp     (ts_rdata),
      .window_ms (window_ff),
      .expire    (expire)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         maxreq_ff <= MAXREQ_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_WINDOW: window_ff <= csr_wdata;
            REG_MAXREQ: maxreq_ff <= csr_wdata[MAXREQ_W-1:0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         meta_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         meta_vld_ff  <= meta_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and response payload registers
   always_ff @(posedge clock) begin
      tidx_ff        <= tidx_in;
      now_ff         <= now_in;
      oor_ff         <= oor_in;
      head_ff        <= head_in;
      count_ff       <= count_in;
      dropped_ff     <= dropped_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   // descriptor of the current tenant, empty until first written
   always_comb begin
      if (meta_vld_ff[tidx_ff]) begin
         head0 = meta_rdata.head;
         cnt0  = (meta_rdata.count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : meta_rdata.count;
      end else begin
         head0 = '0;
         cnt0  = '0;
      end
      head_nx = slot_add(head_ff, CNT_W'(1));
      limit   = (32'(maxreq_ff) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(maxreq_ff);
      allowed = !oor_ff && (count_ff < limit);
      fin_go  = !rsp_valid_ff || rsp_ready;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      tidx_in        = tidx_ff;
      now_in         = now_ff;
      oor_in         = oor_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      dropped_in     = dropped_ff;
      meta_vld_in    = meta_vld_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_occ_in     = rsp_occ_ff;
      req_ready      = 1'b0;
      meta_raddr     = tidx_ff;
      meta_we        = 1'b0;
      meta_wdata     = '{head: head_ff, count: count_ff};
      ts_we          = 1'b0;
      ts_waddr       = ts_addr(tidx_ff, slot_add(head_ff, count_ff));
      ts_raddr       = ts_addr(tidx_ff, head_ff);

      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            meta_raddr = TIDX_W'(req_tenant);
            if (req_valid) begin
               tidx_in  = TIDX_W'(req_tenant);
               now_in   = req_now_ms;
               oor_in   = 32'(req_tenant) >= TENANTS;
               state_in = ST_META;
            end
         end
         ST_META: begin
            head_in    = head0;
            count_in   = cnt0;
            dropped_in = '0;
            ts_raddr   = ts_addr(tidx_ff, head0);
            if (oor_ff) begin
               count_in = '0;
               state_in = ST_FIN;
            end else if (cnt0 != '0) begin
               state_in = ST_CHK;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_CHK: begin
            ts_raddr = ts_addr(tidx_ff, head_nx);
            if (expire) begin
               head_in    = head_nx;
               count_in   = count_ff - CNT_W'(1);
               dropped_in = dropped_ff + CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_FIN;
               end
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = allowed;
               rsp_expired_in = OUTCNT_W'(dropped_ff);
               rsp_occ_in     = allowed ? OUTCNT_W'(count_ff + CNT_W'(1))
                                        : OUTCNT_W'(count_ff);
               ts_we          = allowed;
               meta_we        = !oor_ff;
               meta_wdata     = '{head: head_ff,
                                  count: allowed ? count_ff + CNT_W'(1) : count_ff};
               if (!oor_ff) begin
                  meta_vld_in[tidx_ff] = 1'b1;
               end
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_allowed   = rsp_allowed_ff;
   assign rsp_expired   = rsp_expired_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // memories are only written while the transaction retires
   a_writes_at_fin: assert property (@(posedge clock) disable iff (reset)
      (ts_we || meta_we) |-> (state_ff == ST_FIN && fin_go))
      else $error("memory write outside the retire cycle");

   // an expiry check always has an entry to look at
   a_chk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK) |-> (count_ff != '0 && !oor_ff))
      else $error("expiry check on an empty queue");

   // an admitted request always yields a valid, allowed response
   a_admit_occ: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && fin_go && allowed) |=> (rsp_valid && rsp_allowed))
      else $error("admitted request lost its response");

   // a new request is only taken once the previous one has retired
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_META))
      else $error("request accepted while another is in flight");

endmodule

`default_nettype wire
